>>> design/wpsm_pkg.sv
// Package for the wheel pulse speed meter: constants, register indexes and controller types.
package wpsm_pkg;

    // Field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned SPEED_W = 16;

    // APB: three 32-bit registers at byte addresses 0, 4 and 8
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned REG_IDX_W  = 2;

    // Register reset values
    localparam logic [CFG_W-1:0] LOCKOUT_RST  = 16'd100;
    localparam logic [CFG_W-1:0] DISTANCE_RST = 16'd1953;
    localparam logic [CFG_W-1:0] IDLE_RST     = 16'd2;

    // Register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_LOCKOUT  = 2'd0,
        REG_DISTANCE = 2'd1,
        REG_IDLE     = 2'd2
    } reg_idx_t;

    // Input word command codes
    localparam logic CMD_EDGE    = 1'b0;
    localparam logic CMD_REFRESH = 1'b1;

    // Serial divider: one quotient bit per step, quotient as wide as the dividend
    localparam int unsigned DIV_STEPS = CFG_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic edge_upd;   // take a sensor edge
        logic start;      // take a refresh, load the divider
        logic div_step;   // one divider step
        logic finish;     // load the output register, update the average
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_refresh; // command of the word on offer
    } dp_status_t;

endpackage

>>> design/wpsm_in_if.sv
// Input channel: sensor edge or refresh word with valid/ready handshake.
interface wpsm_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] time_ms;

    modport source (output valid, output command, output time_ms, input ready);
    modport sink   (input valid, input command, input time_ms, output ready);
endinterface

>>> design/wpsm_out_if.sv
// Output channel: one result word per refresh with valid/ready handshake.
interface wpsm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] interval_ms;
    logic [15:0] speed;
    logic [15:0] average_speed;

    modport source (output valid, output interval_ms, output speed, output average_speed,
                    input ready);
    modport sink   (input valid, input interval_ms, input speed, input average_speed,
                    output ready);
endinterface

>>> design/wpsm_apb.sv
// APB register file holding lockout, distance per rotation and idle speed.
module wpsm_apb
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wpsm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wpsm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wpsm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [wpsm_pkg::CFG_W-1:0]          lockout_ms,
    output logic [wpsm_pkg::CFG_W-1:0]          distance_per_rotation,
    output logic [wpsm_pkg::CFG_W-1:0]          idle_speed
);

    logic [wpsm_pkg::CFG_W-1:0]     lockout_reg;
    logic [wpsm_pkg::CFG_W-1:0]     distance_reg;
    logic [wpsm_pkg::CFG_W-1:0]     idle_reg;
    logic [wpsm_pkg::REG_IDX_W-1:0] idx;
    logic                           wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[wpsm_pkg::APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;

    // Register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg  <= wpsm_pkg::LOCKOUT_RST;
            distance_reg <= wpsm_pkg::DISTANCE_RST;
            idle_reg     <= wpsm_pkg::IDLE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                wpsm_pkg::REG_LOCKOUT:  lockout_reg  <= pwdata[wpsm_pkg::CFG_W-1:0];
                wpsm_pkg::REG_DISTANCE: distance_reg <= pwdata[wpsm_pkg::CFG_W-1:0];
                wpsm_pkg::REG_IDLE:     idle_reg     <= pwdata[wpsm_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        unique case (idx)
            wpsm_pkg::REG_LOCKOUT:  prdata = {16'd0, lockout_reg};
            wpsm_pkg::REG_DISTANCE: prdata = {16'd0, distance_reg};
            wpsm_pkg::REG_IDLE:     prdata = {16'd0, idle_reg};
            default:                prdata = '0;
        endcase
    end

    assign lockout_ms            = lockout_reg;
    assign distance_per_rotation = distance_reg;
    assign idle_speed            = idle_reg;

endmodule

>>> design/wpsm_ctrl.sv
// Controller: sequences edge capture, the serial division and the output word.
module wpsm_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  wpsm_pkg::dp_status_t    status,
    output wpsm_pkg::ctrl_cmd_t     cmd
);

    wpsm_pkg::ctrl_state_t          state_reg;
    wpsm_pkg::ctrl_state_t          state_next;
    logic [wpsm_pkg::STEP_W-1:0]    step_reg;
    logic [wpsm_pkg::STEP_W-1:0]    step_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wpsm_pkg::ST_IDLE:
            begin
                if (in_valid && status.is_refresh)
                    state_next = wpsm_pkg::ST_DIV;
            end
            wpsm_pkg::ST_DIV:
            begin
                if (step_reg == wpsm_pkg::STEP_LAST)
                    state_next = wpsm_pkg::ST_FINISH;
            end
            wpsm_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = wpsm_pkg::ST_IDLE;
            end
            default: state_next = wpsm_pkg::ST_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            wpsm_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.edge_upd = in_valid && !status.is_refresh;
                cmd.start    = in_valid && status.is_refresh;
            end
            wpsm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            wpsm_pkg::ST_FINISH:
            begin
                cmd.finish = !out_valid_reg || out_ready;
            end
            default: ;
        endcase
    end

    // Step counter and output valid
    always_comb
    begin
        step_next = step_reg;
        if (cmd.start)
            step_next = '0;
        else if (cmd.div_step)
            step_next = step_reg + 1'b1;

        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wpsm_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A new result appears only out of the finishing step
    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == wpsm_pkg::ST_FINISH))
        else $error("output valid rose outside the finishing step");

    // A refresh starts the divider from its first step
    a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == wpsm_pkg::ST_DIV) && (step_reg == '0))
        else $error("divider not started on refresh");

    // The divider runs exactly its full count of steps
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wpsm_pkg::ST_DIV) && (step_reg == wpsm_pkg::STEP_LAST)
        |=> state_reg == wpsm_pkg::ST_FINISH)
        else $error("divider did not end after its last step");

    // A finished result waits while the previous one is still held
    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wpsm_pkg::ST_FINISH) && out_valid_reg && !out_ready
        |=> (state_reg == wpsm_pkg::ST_FINISH) && out_valid_reg)
        else $error("result overwrote a word not yet taken");

endmodule

>>> design/wpsm_dp.sv
// Datapath: edge timing, pending interval, restoring divider, average and output register.
module wpsm_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  wpsm_pkg::ctrl_cmd_t             cmd,
    output wpsm_pkg::dp_status_t            status,
    input  logic                            command,
    input  logic [wpsm_pkg::TIME_W-1:0]     time_ms,
    input  logic [wpsm_pkg::CFG_W-1:0]      lockout_ms,
    input  logic [wpsm_pkg::CFG_W-1:0]      distance_per_rotation,
    input  logic [wpsm_pkg::CFG_W-1:0]      idle_speed,
    output logic [wpsm_pkg::TIME_W-1:0]     interval_ms,
    output logic [wpsm_pkg::SPEED_W-1:0]    speed,
    output logic [wpsm_pkg::SPEED_W-1:0]    average_speed
);

    logic [wpsm_pkg::TIME_W-1:0]    last_edge_reg;
    logic [wpsm_pkg::TIME_W-1:0]    pending_reg;
    logic [wpsm_pkg::SPEED_W-1:0]   average_reg;
    logic [wpsm_pkg::TIME_W-1:0]    divisor_reg;   // interval taken at refresh
    logic [wpsm_pkg::TIME_W-1:0]    rem_reg;
    logic [wpsm_pkg::CFG_W-1:0]     quot_reg;      // dividend shifts out, quotient in
    logic [wpsm_pkg::TIME_W-1:0]    out_interval_reg;
    logic [wpsm_pkg::SPEED_W-1:0]   out_speed_reg;
    logic [wpsm_pkg::SPEED_W-1:0]   out_average_reg;

    logic [wpsm_pkg::TIME_W-1:0]    delta;
    logic                           edge_ok;
    logic [wpsm_pkg::TIME_W:0]      trial;
    logic [wpsm_pkg::TIME_W:0]      trial_diff;
    logic                           qbit;
    logic [wpsm_pkg::SPEED_W-1:0]   speed_val;
    logic [wpsm_pkg::SPEED_W:0]     avg_sum;
    logic [wpsm_pkg::SPEED_W-1:0]   average_new;

    assign status.is_refresh = (command == wpsm_pkg::CMD_REFRESH);

    // Edge interval with wrap, bounce rejection
    assign delta   = time_ms - last_edge_reg;
    assign edge_ok = delta >= {16'd0, lockout_ms};

    // Restoring division step
    assign trial      = {rem_reg, quot_reg[wpsm_pkg::CFG_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign qbit       = trial >= {1'b0, divisor_reg};

    // Speed and halving average
    assign speed_val   = (divisor_reg != '0) ? quot_reg : '0;
    assign avg_sum     = {1'b0, average_reg} + {1'b0, speed_val};
    assign average_new = (speed_val > idle_speed) ? avg_sum[wpsm_pkg::SPEED_W:1] : average_reg;

    // Meter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg <= '0;
            pending_reg   <= '0;
            average_reg   <= '0;
        end
        else
        begin
            if (cmd.edge_upd && edge_ok)
            begin
                last_edge_reg <= time_ms;
                pending_reg   <= delta;
            end
            else if (cmd.start)
                pending_reg <= '0;
            if (cmd.finish)
                average_reg <= average_new;
        end
    end

    // Divider and output word
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            divisor_reg <= pending_reg;
            rem_reg     <= '0;
            quot_reg    <= distance_per_rotation;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= qbit ? trial_diff[wpsm_pkg::TIME_W-1:0] : trial[wpsm_pkg::TIME_W-1:0];
            quot_reg <= {quot_reg[wpsm_pkg::CFG_W-2:0], qbit};
        end
        if (cmd.finish)
        begin
            out_interval_reg <= divisor_reg;
            out_speed_reg    <= speed_val;
            out_average_reg  <= average_new;
        end
    end

    assign interval_ms   = out_interval_reg;
    assign speed         = out_speed_reg;
    assign average_speed = out_average_reg;

endmodule

>>> design/wheel_pulse_speed_meter.sv
// Top level of the wheel pulse speed meter.
// A sensor edge word yields no result; an edge that comes sooner than lockout_ms
// after the last accepted edge (32-bit wrap) is dropped as bounce. A refresh word
// passes through steps: one to take the pending interval, 16 in the bit-serial
// restoring divider (one quotient bit per cycle for the 16-bit distance), and one
// to update the average and load the output register, which may stretch while
// the previous result is still held. The result word sits in its own register, so
// edges are taken while it waits. Registers are written over APB at 0x0, 0x4 and 0x8.
module wheel_pulse_speed_meter
(
    input  logic                                clk,
    input  logic                                rst_n,
    wpsm_in_if.sink                             in_ch,
    wpsm_out_if.source                          out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wpsm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wpsm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wpsm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    wpsm_pkg::ctrl_cmd_t            cmd;
    wpsm_pkg::dp_status_t           status;
    logic [wpsm_pkg::CFG_W-1:0]     lockout_ms;
    logic [wpsm_pkg::CFG_W-1:0]     distance_per_rotation;
    logic [wpsm_pkg::CFG_W-1:0]     idle_speed;

    // Configuration registers
    wpsm_apb u_apb
    (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready),
        .lockout_ms             (lockout_ms),
        .distance_per_rotation  (distance_per_rotation),
        .idle_speed             (idle_speed)
    );

    // Sequencer
    wpsm_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Arithmetic and state
    wpsm_dp u_dp
    (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cmd                    (cmd),
        .status                 (status),
        .command                (in_ch.command),
        .time_ms                (in_ch.time_ms),
        .lockout_ms             (lockout_ms),
        .distance_per_rotation  (distance_per_rotation),
        .idle_speed             (idle_speed),
        .interval_ms            (out_ch.interval_ms),
        .speed                  (out_ch.speed),
        .average_speed          (out_ch.average_speed)
    );

endmodule
